[sv/qer_pkg.sv]
`timescale 1ns / 1ps
package qer_pkg;

  localparam int unsigned CoefW  = 16;
  localparam int unsigned RootW  = 32;
  localparam int unsigned DiscW  = 35;  // signed discriminant b*b - 4*a*c
  localparam int unsigned RemW   = 34;  // non-negative discriminant
  localparam int unsigned SqrtW  = 17;  // integer root of the discriminant
  localparam int unsigned NumW   = 18;  // signed numerator and denominator
  localparam int unsigned MagW   = 17;  // their magnitudes
  localparam int unsigned ScaleW = 16;  // Q16.16 result scaling
  localparam int unsigned QuotW  = MagW + ScaleW;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNegDisc = 2'd1,
    StZeroA   = 2'd2,
    StSat     = 2'd3
  } status_e;

  // flags carried along the root stages
  typedef struct packed {
    logic func;
    logic zero_a;
    logic neg_disc;
  } sqrt_side_t;

  // flags carried along the divider stages
  typedef struct packed {
    logic zero_a;
    logic neg_disc;
    logic neg_p;
    logic neg_m;
  } div_side_t;

endpackage

[sv/quadratic_equation_roots.sv]
`timescale 1ns / 1ps
// channel  valid          stall          payload
// request  valid_i        stall_o        func_i coef_a_i coef_b_i coef_c_i
// result   valid_o        stall_i        root_plus_o root_minus_o status_o
//
// one request enters per cycle while stall_o is low; the pipeline holds products,
// discriminant, 17 root stages (one root bit each), numerator, 33 divider stages
// (one quotient bit each) and the output register.
// rst_ni clears only the valid bits; the data path registers have no reset.
// a stalled result freezes the whole pipeline, so nothing is lost or repeated.
module quadratic_equation_roots (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic                                 func_i,
  input  logic signed [qer_pkg::CoefW-1:0]     coef_a_i,
  input  logic signed [qer_pkg::CoefW-1:0]     coef_b_i,
  input  logic signed [qer_pkg::CoefW-1:0]     coef_c_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [qer_pkg::RootW-1:0]     root_plus_o,
  output logic signed [qer_pkg::RootW-1:0]     root_minus_o,
  output logic [1:0]                           status_o
);

  localparam int unsigned CW = qer_pkg::CoefW;
  localparam int unsigned SW = qer_pkg::SqrtW;
  localparam int unsigned RW = qer_pkg::RemW;
  localparam int unsigned DW = qer_pkg::DiscW;
  localparam int unsigned MW = qer_pkg::MagW;
  localparam int unsigned QW = qer_pkg::QuotW;
  localparam int unsigned NW = qer_pkg::NumW;
  localparam int unsigned OW = qer_pkg::RootW;

  logic en;
  logic out_vld_q;

  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  // products
  logic                      p_vld_q;
  logic                      p_func_q;
  logic signed [CW-1:0]      p_a_q, p_b_q;
  logic signed [2*CW-1:0]    p_bb_q, p_ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_func_q <= func_i;
      p_a_q    <= coef_a_i;
      p_b_q    <= coef_b_i;
      p_bb_q   <= coef_b_i * coef_b_i;
      p_ac_q   <= coef_a_i * coef_c_i;
    end
  end

  // discriminant, then root stages
  logic signed [DW-1:0]  disc;
  logic                  s_vld_q  [0:SW];
  logic [RW-1:0]         s_rem_q  [0:SW];
  logic [SW-1:0]         s_root_q [0:SW];
  logic signed [CW-1:0]  s_a_q    [0:SW];
  logic signed [CW-1:0]  s_b_q    [0:SW];
  qer_pkg::sqrt_side_t   s_side_q [0:SW];

  assign disc = {{(DW-2*CW){p_bb_q[2*CW-1]}}, p_bb_q}
              - {{(DW-2*CW-2){p_ac_q[2*CW-1]}}, p_ac_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q[0] <= 1'b0;
    end else if (en) begin
      s_vld_q[0] <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_rem_q[0]  <= (disc[DW-1] || !p_func_q) ? '0 : disc[RW-1:0];
      s_root_q[0] <= '0;
      s_a_q[0]    <= p_a_q;
      s_b_q[0]    <= p_b_q;
      s_side_q[0] <= '{func: p_func_q, zero_a: (p_a_q == '0),
                       neg_disc: p_func_q && disc[DW-1]};
    end
  end

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam int unsigned K = SW - 1 - j;
    logic [DW-1:0] trial;
    logic          take;

    assign trial = ({{(DW-SW){1'b0}}, s_root_q[j]} << (K + 1))
                 + ({{(DW-1){1'b0}}, 1'b1} << (2 * K));
    assign take  = {1'b0, s_rem_q[j]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        s_vld_q[j+1] <= s_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_rem_q[j+1]  <= take ? (s_rem_q[j] - trial[RW-1:0]) : s_rem_q[j];
        s_root_q[j+1] <= take ? (s_root_q[j] | (SW'(1) << K)) : s_root_q[j];
        s_a_q[j+1]    <= s_a_q[j];
        s_b_q[j+1]    <= s_b_q[j];
        s_side_q[j+1] <= s_side_q[j];
      end
    end
  end

  // numerators and denominator
  logic signed [NW-1:0] neg_b, num_p, num_m, den;
  qer_pkg::sqrt_side_t  ss;

  assign ss    = s_side_q[SW];
  assign neg_b = -{{(NW-CW){s_b_q[SW][CW-1]}}, s_b_q[SW]};
  assign num_p = ss.func ? neg_b + {1'b0, s_root_q[SW]} : neg_b;
  assign num_m = ss.func ? neg_b - {1'b0, s_root_q[SW]} : '0;
  assign den   = ss.func ? {s_a_q[SW][CW-1], s_a_q[SW], 1'b0}
                         : {{(NW-CW){s_a_q[SW][CW-1]}}, s_a_q[SW]};

  logic                d_vld_q  [0:QW];
  logic [MW-1:0]       d_den_q  [0:QW];
  logic [MW-1:0]       d_np_q   [0:QW];
  logic [MW-1:0]       d_nm_q   [0:QW];
  logic [MW-1:0]       d_rp_q   [0:QW];
  logic [MW-1:0]       d_rm_q   [0:QW];
  logic [QW-1:0]       d_qp_q   [0:QW];
  logic [QW-1:0]       d_qm_q   [0:QW];
  qer_pkg::div_side_t  d_side_q [0:QW];

  logic signed [NW-1:0] abs_p, abs_m, abs_d;
  assign abs_p = num_p[NW-1] ? -num_p : num_p;
  assign abs_m = num_m[NW-1] ? -num_m : num_m;
  assign abs_d = den[NW-1] ? -den : den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q[0] <= 1'b0;
    end else if (en) begin
      d_vld_q[0] <= s_vld_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_den_q[0]  <= abs_d[MW-1:0];
      d_np_q[0]   <= abs_p[MW-1:0];
      d_nm_q[0]   <= abs_m[MW-1:0];
      d_rp_q[0]   <= '0;
      d_rm_q[0]   <= '0;
      d_qp_q[0]   <= '0;
      d_qm_q[0]   <= '0;
      d_side_q[0] <= '{zero_a: ss.zero_a, neg_disc: ss.neg_disc,
                       neg_p: num_p[NW-1] ^ den[NW-1],
                       neg_m: num_m[NW-1] ^ den[NW-1]};
    end
  end

  // restoring division of |num| * 2^16 by |den|, one quotient bit a stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned B = QW - 1 - j;
    logic [QW-1:0]  dvd_p, dvd_m;
    logic [MW:0]    tp, tm, dd;
    logic           gp, gm;

    assign dvd_p = {d_np_q[j], {qer_pkg::ScaleW{1'b0}}};
    assign dvd_m = {d_nm_q[j], {qer_pkg::ScaleW{1'b0}}};
    assign tp    = {d_rp_q[j], dvd_p[B]};
    assign tm    = {d_rm_q[j], dvd_m[B]};
    assign dd    = {1'b0, d_den_q[j]};
    assign gp    = tp >= dd;
    assign gm    = tm >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        d_vld_q[j+1] <= d_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_den_q[j+1]  <= d_den_q[j];
        d_np_q[j+1]   <= d_np_q[j];
        d_nm_q[j+1]   <= d_nm_q[j];
        d_rp_q[j+1]   <= gp ? MW'(tp - dd) : tp[MW-1:0];
        d_rm_q[j+1]   <= gm ? MW'(tm - dd) : tm[MW-1:0];
        d_qp_q[j+1]   <= d_qp_q[j] | ({{(QW-1){1'b0}}, gp} << B);
        d_qm_q[j+1]   <= d_qm_q[j] | ({{(QW-1){1'b0}}, gm} << B);
        d_side_q[j+1] <= d_side_q[j];
      end
    end
  end

  // sign, saturation and status
  qer_pkg::div_side_t  ds;
  logic [OW-1:0]       rp_d, rm_d;
  logic                sat_p, sat_m;
  logic [1:0]          status_d;
  logic [OW-1:0]       rp_q, rm_q;
  logic [1:0]          status_q;

  assign ds = d_side_q[QW];

  always_comb begin
    logic [QW-1:0] qp, qm;
    qp = d_qp_q[QW];
    qm = d_qm_q[QW];
    if (ds.neg_p) begin
      sat_p = qp > {{(QW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}};
      rp_d  = sat_p ? {1'b1, {(OW-1){1'b0}}} : -qp[OW-1:0];
    end else begin
      sat_p = qp[QW-1:OW-1] != '0;
      rp_d  = sat_p ? {1'b0, {(OW-1){1'b1}}} : qp[OW-1:0];
    end
    if (ds.neg_m) begin
      sat_m = qm > {{(QW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}};
      rm_d  = sat_m ? {1'b1, {(OW-1){1'b0}}} : -qm[OW-1:0];
    end else begin
      sat_m = qm[QW-1:OW-1] != '0;
      rm_d  = sat_m ? {1'b0, {(OW-1){1'b1}}} : qm[OW-1:0];
    end
    status_d = qer_pkg::StOk;
    if (ds.zero_a) begin
      status_d = qer_pkg::StZeroA;
      rp_d     = '0;
      rm_d     = '0;
    end else if (ds.neg_disc) begin
      status_d = qer_pkg::StNegDisc;
      rp_d     = '0;
      rm_d     = '0;
    end else if (sat_p || sat_m) begin
      status_d = qer_pkg::StSat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rp_q     <= rp_d;
      rm_q     <= rm_d;
      status_q <= status_d;
    end
  end

  assign valid_o      = out_vld_q;
  assign root_plus_o  = rp_q;
  assign root_minus_o = rm_q;
  assign status_o     = status_q;

endmodule
